// ----- design/aff2i_pkg.sv -----
// Shared widths, types and helper functions for the 2D affine inverse unit.
package aff2i_pkg;

    localparam int DATA_W    = 32;
    localparam int SIGN_W    = 2;
    localparam int PROD_W    = 64;
    localparam int MAG_W     = 64;
    localparam int QUO_W     = 32;
    localparam int FRONT_LAT = 3;
    localparam int DIV_LAT   = QUO_W + 2;
    localparam int NUM_LANES = 6;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_lane;

    typedef struct packed {
        logic [SIGN_W-1:0] sgn;
        logic              sing;
    } t_meta;

    function automatic t_lane lane_of32(logic signed [DATA_W-1:0] x, logic negate);
        t_lane             l;
        logic [DATA_W-1:0] a;
        a     = x[DATA_W-1] ? (~x + 1'b1) : x;
        l.neg = x[DATA_W-1] ^ negate;
        l.mag = MAG_W'(a);
        return l;
    endfunction

    function automatic t_lane lane_of65(logic signed [PROD_W:0] x);
        t_lane           l;
        logic [PROD_W:0] a;
        a     = x[PROD_W] ? (~x + 1'b1) : x;
        l.neg = x[PROD_W];
        l.mag = a[MAG_W-1:0];
        return l;
    endfunction

endpackage

// ----- design/aff2i_if.sv -----
// Request and result channel interfaces of the 2D affine inverse unit.
interface aff2i_req_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [aff2i_pkg::DATA_W-1:0]     m11;
    logic signed [aff2i_pkg::DATA_W-1:0]     m12;
    logic signed [aff2i_pkg::DATA_W-1:0]     m13;
    logic signed [aff2i_pkg::DATA_W-1:0]     m21;
    logic signed [aff2i_pkg::DATA_W-1:0]     m22;
    logic signed [aff2i_pkg::DATA_W-1:0]     m23;
    logic signed [aff2i_pkg::SIGN_W-1:0]     orient_sign;

    modport source (output valid, m11, m12, m13, m21, m22, m23, orient_sign, input ready);
    modport sink   (input valid, m11, m12, m13, m21, m22, m23, orient_sign, output ready);
endinterface

interface aff2i_res_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [aff2i_pkg::DATA_W-1:0]     r11;
    logic signed [aff2i_pkg::DATA_W-1:0]     r12;
    logic signed [aff2i_pkg::DATA_W-1:0]     r13;
    logic signed [aff2i_pkg::DATA_W-1:0]     r21;
    logic signed [aff2i_pkg::DATA_W-1:0]     r22;
    logic signed [aff2i_pkg::DATA_W-1:0]     r23;
    logic signed [aff2i_pkg::SIGN_W-1:0]     out_sign;
    logic                                    ok;

    modport source (output valid, r11, r12, r13, r21, r22, r23, out_sign, ok, input ready);
    modport sink   (input valid, r11, r12, r13, r21, r22, r23, out_sign, ok, output ready);
endinterface

// ----- design/aff2i_front.sv -----
// Front end: products, determinant and numerators, split into sign and magnitude.
module aff2i_front (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic signed [aff2i_pkg::DATA_W-1:0]    i_m11,
    input  logic signed [aff2i_pkg::DATA_W-1:0]    i_m12,
    input  logic signed [aff2i_pkg::DATA_W-1:0]    i_m13,
    input  logic signed [aff2i_pkg::DATA_W-1:0]    i_m21,
    input  logic signed [aff2i_pkg::DATA_W-1:0]    i_m22,
    input  logic signed [aff2i_pkg::DATA_W-1:0]    i_m23,
    input  logic [aff2i_pkg::SIGN_W-1:0]           i_sgn,
    output aff2i_pkg::t_lane                       o_den,
    output aff2i_pkg::t_lane [aff2i_pkg::NUM_LANES-1:0] o_num,
    output aff2i_pkg::t_meta                       o_meta
);
    localparam int DW = aff2i_pkg::DATA_W;
    localparam int PW = aff2i_pkg::PROD_W;

    logic signed [PW-1:0] r_p1122, r_p1221, r_p1223, r_p2213, r_p1321, r_p1123;
    logic signed [DW-1:0] r_m11_1, r_m12_1, r_m21_1, r_m22_1;
    logic [aff2i_pkg::SIGN_W-1:0] r_sgn_1, r_sgn_2;
    logic signed [PW:0]   r_det_2, r_n13_2, r_n23_2;
    logic signed [DW-1:0] r_m11_2, r_m12_2, r_m21_2, r_m22_2;
    aff2i_pkg::t_lane     r_den_3;
    aff2i_pkg::t_lane [aff2i_pkg::NUM_LANES-1:0] r_num_3;
    aff2i_pkg::t_meta     r_meta_3;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1122 <= i_m11 * i_m22;
            r_p1221 <= i_m12 * i_m21;
            r_p1223 <= i_m12 * i_m23;
            r_p2213 <= i_m22 * i_m13;
            r_p1321 <= i_m13 * i_m21;
            r_p1123 <= i_m11 * i_m23;
            r_m11_1 <= i_m11;
            r_m12_1 <= i_m12;
            r_m21_1 <= i_m21;
            r_m22_1 <= i_m22;
            r_sgn_1 <= i_sgn;

            r_det_2 <= (PW+1)'(r_p1122) - (PW+1)'(r_p1221);
            r_n13_2 <= (PW+1)'(r_p1223) - (PW+1)'(r_p2213);
            r_n23_2 <= (PW+1)'(r_p1321) - (PW+1)'(r_p1123);
            r_m11_2 <= r_m11_1;
            r_m12_2 <= r_m12_1;
            r_m21_2 <= r_m21_1;
            r_m22_2 <= r_m22_1;
            r_sgn_2 <= r_sgn_1;

            r_den_3       <= aff2i_pkg::lane_of65(r_det_2);
            r_num_3[0]    <= aff2i_pkg::lane_of32(r_m22_2, 1'b0);
            r_num_3[1]    <= aff2i_pkg::lane_of32(r_m12_2, 1'b1);
            r_num_3[2]    <= aff2i_pkg::lane_of65(r_n13_2);
            r_num_3[3]    <= aff2i_pkg::lane_of32(r_m21_2, 1'b1);
            r_num_3[4]    <= aff2i_pkg::lane_of32(r_m11_2, 1'b0);
            r_num_3[5]    <= aff2i_pkg::lane_of65(r_n23_2);
            r_meta_3.sgn  <= r_sgn_2;
            r_meta_3.sing <= (r_sgn_2 == '0) || (r_det_2 == '0);
        end
    end

    assign o_den  = r_den_3;
    assign o_num  = r_num_3;
    assign o_meta = r_meta_3;

endmodule

// ----- design/aff2i_div.sv -----
// Pipelined restoring divider with one quotient bit per stage, rounding and saturation.
module aff2i_div #(
    parameter int SHIFT = 32
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  aff2i_pkg::t_lane              i_num,
    input  aff2i_pkg::t_lane              i_den,
    output logic [aff2i_pkg::DATA_W-1:0]  o_res
);
    localparam int MW = aff2i_pkg::MAG_W;
    localparam int QB = aff2i_pkg::QUO_W;
    localparam int DW = aff2i_pkg::DATA_W;
    localparam int NW = MW + SHIFT;
    localparam int HW = NW - QB;
    localparam int CW = ((HW > MW) ? HW : MW) + 1;
    localparam int RW = MW + 1;

    logic [NW-1:0] n_n2;
    logic [CW-1:0] n_hi, n_dx;

    logic [RW-1:0] r_rem [0:QB];
    logic [QB-1:0] r_q   [0:QB];
    logic [MW-1:0] r_den [0:QB];
    logic          r_neg [0:QB];
    logic          r_ovf [0:QB];
    logic [QB-1:0] r_low [0:QB-1];
    logic [DW-1:0] r_res;

    always_comb begin
        n_n2 = {i_num.mag, {SHIFT{1'b0}}};
        n_hi = CW'(n_n2[NW-1:QB]);
        n_dx = CW'(i_den.mag);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= RW'(n_hi);
            r_q[0]   <= '0;
            r_low[0] <= n_n2[QB-1:0];
            r_den[0] <= i_den.mag;
            r_neg[0] <= i_num.neg ^ i_den.neg;
            r_ovf[0] <= n_hi >= n_dx;
        end
    end

    for (genvar g = 0; g < QB; g++) begin : g_stage
        logic [RW-1:0] w_sh, w_df;
        logic          w_ge;

        assign w_sh = {r_rem[g][MW-1:0], r_low[g][QB-1-g]};
        assign w_df = w_sh - RW'(r_den[g]);
        assign w_ge = w_sh >= RW'(r_den[g]);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1] <= w_ge ? w_df : w_sh;
                r_q[g+1]   <= {r_q[g][QB-2:0], w_ge};
                r_den[g+1] <= r_den[g];
                r_neg[g+1] <= r_neg[g];
                r_ovf[g+1] <= r_ovf[g];
            end
        end

        if (g < QB-1) begin : g_low
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_low[g+1] <= r_low[g];
                end
            end
        end
    end

    logic          w_rnd, w_sat;
    logic [QB:0]   w_qr, w_lim, w_mag;

    always_comb begin
        w_rnd = r_rem[QB] >= (RW'(r_den[QB]) - r_rem[QB]);
        w_qr  = {1'b0, r_q[QB]} + (QB+1)'(w_rnd);
        w_lim = {1'b0, r_neg[QB], {(DW-1){~r_neg[QB]}}};
        w_sat = r_ovf[QB] || (w_qr > w_lim);
        w_mag = w_sat ? w_lim : w_qr;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= r_neg[QB] ? (~w_mag[DW-1:0] + 1'b1) : w_mag[DW-1:0];
        end
    end

    assign o_res = r_res;

endmodule

// ----- design/affine_2d_inverse_unit.sv -----
// Top level of the 2D affine inverse unit: valid pipeline, lane dividers and result port.
// The unit takes one 2x3 affine transform per clock while it is not stalled and returns its
// inverse through the products, the determinant and the sign and magnitude split, then six
// parallel dividers that each resolve one quotient bit per stage before a rounding and
// saturation stage, whose register drives the result port. The whole pipeline advances
// together; it holds while a result waits and the result side is not ready, so i_req.ready
// follows o_res.ready combinationally.
module affine_2d_inverse_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    aff2i_req_if.sink    i_req,
    aff2i_res_if.source  o_res
);
    localparam int LAT = aff2i_pkg::FRONT_LAT + aff2i_pkg::DIV_LAT;
    localparam int NL  = aff2i_pkg::NUM_LANES;

    logic                  w_en;
    aff2i_pkg::t_lane      w_den;
    aff2i_pkg::t_lane [NL-1:0] w_num;
    aff2i_pkg::t_meta      w_meta;
    logic [aff2i_pkg::DATA_W-1:0] w_q [0:NL-1];

    logic                  r_vld  [0:LAT-1];
    aff2i_pkg::t_meta      r_meta [0:aff2i_pkg::DIV_LAT-1];

    assign w_en        = !r_vld[LAT-1] || o_res.ready;
    assign i_req.ready = w_en;

    aff2i_front u_front (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_m11  (i_req.m11),
        .i_m12  (i_req.m12),
        .i_m13  (i_req.m13),
        .i_m21  (i_req.m21),
        .i_m22  (i_req.m22),
        .i_m23  (i_req.m23),
        .i_sgn  (i_req.orient_sign),
        .o_den  (w_den),
        .o_num  (w_num),
        .o_meta (w_meta)
    );

    for (genvar g = 0; g < NL; g++) begin : g_lane
        aff2i_div #(
            .SHIFT (((g == 2) || (g == 5)) ? FRAC_BITS : 2 * FRAC_BITS)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (w_num[g]),
            .i_den (w_den),
            .o_res (w_q[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_req.valid;
            for (int k = 1; k < LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_meta[0] <= w_meta;
            for (int k = 1; k < aff2i_pkg::DIV_LAT; k++) begin
                r_meta[k] <= r_meta[k-1];
            end
        end
    end

    aff2i_pkg::t_meta w_om;
    assign w_om = r_meta[aff2i_pkg::DIV_LAT-1];

    assign o_res.valid    = r_vld[LAT-1];
    assign o_res.r11      = w_om.sing ? '0 : w_q[0];
    assign o_res.r12      = w_om.sing ? '0 : w_q[1];
    assign o_res.r13      = w_om.sing ? '0 : w_q[2];
    assign o_res.r21      = w_om.sing ? '0 : w_q[3];
    assign o_res.r22      = w_om.sing ? '0 : w_q[4];
    assign o_res.r23      = w_om.sing ? '0 : w_q[5];
    assign o_res.out_sign = w_om.sgn;
    assign o_res.ok       = !w_om.sing;

    a_ok_needs_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ok) |-> (o_res.out_sign != '0))
        else $error("Successful result carries a zero sign.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> (o_res.valid && $stable(o_res.r13) &&
                                           $stable(o_res.ok)))
        else $error("Stalled result changed.");

    a_ready_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_res.valid |-> i_req.ready)
        else $error("Request refused while the result stage is empty.");

    a_reset_clears: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_res.valid)
        else $error("Result valid straight after reset.");

endmodule
